@@ design/oert_pkg.sv @@
// oert_pkg: shared types and codes for the ordered epoch range table.
// Depends on nothing; imported by the table's top level.
`default_nettype none

package oert_pkg;

   localparam logic [1:0] ACT_APPEND = 2'd0;
   localparam logic [1:0] ACT_TRIM   = 2'd1;
   localparam logic [1:0] ACT_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_MISORDERED = 2'd1;
   localparam logic [1:0] STATUS_FULL       = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND  = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] epoch;
      logic [63:0] sequence_req;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] found_epoch;
      logic [6:0]  entries_held;
   } rsp_word_type;

   // one table entry as stored in the RAM
   typedef struct packed {
      logic [63:0] epoch;
      logic [63:0] seq_first;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAP,
      ST_READ,
      ST_CMP,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

@@ design/oert_ram.sv @@
// oert_ram: simple dual-port synchronous RAM, one write and one read port,
// registered read data. No package dependencies.
`default_nettype none

module oert_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ design/ordered_epoch_range_table.sv @@
// ordered_epoch_range_table: circular table of (epoch, first sequence) entries
// with append, trim and lookup. Depends on oert_pkg and oert_ram.
//
//   channel  dir  handshake              word
//   req      in   req_valid / req_stall  req_word_type  (action, epoch, sequence_req)
//   rsp      out  rsp_valid / rsp_stall  rsp_word_type  (status, found_epoch, entries_held)
//   csr      in   csr_write_en           csr_write_data (max_entries)
//
// One word at a time. Append, unused codes and lookups past the newest entry (or on an
// empty table) go from accept straight to ST_EMIT. Lookup: binary search over the held
// entries, ST_READ then ST_CMP per step; trim first applies the max_entries cap in
// ST_CAP and then searches the capped entries. One RAM read per search step.
// Reset (synchronous) empties the table and sets max_entries to 64; no clearing pass.
// A result waiting on rsp_stall does not block req; the next word is processed and then
// held in its final state until the output register frees.
`default_nettype none

module ordered_epoch_range_table
   import oert_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word,
   input  wire logic         csr_write_en,
   input  wire logic [6:0]   csr_write_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int EXT_W = (CNT_W > 7) ? CNT_W : 7;
   localparam int ENT_W = $bits(entry_type);

   // oldest + pos modulo depth; pos never exceeds the depth
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] pos);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(pos);
      if (sum >= (CNT_W+1)'(TABLE_DEPTH)) begin
         sum = sum - (CNT_W+1)'(TABLE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   oldest_ff, oldest_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [6:0]         max_ff;
   logic [63:0]        newest_epoch_ff, newest_epoch_in;
   logic [63:0]        newest_seq_ff, newest_seq_in;
   logic [1:0]         act_ff, act_in;
   logic [63:0]        key_ff, key_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   mid_ff, mid_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic [63:0]        res_found_ff, res_found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   entry_type          mem_wdata;
   logic               mem_re;
   logic [IDX_W-1:0]   mem_raddr;
   logic [ENT_W-1:0]   mem_rdata;
   entry_type          rd_entry;

   logic [CNT_W:0]     mid_sum;
   logic [CNT_W-1:0]   mid_calc;
   logic [EXT_W-1:0]   count_ext;
   logic [EXT_W-1:0]   max_ext;
   logic [CNT_W-1:0]   cap_count;
   logic               take;

   oert_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rd_entry  = mem_rdata;
   assign mid_sum   = (CNT_W+1)'(lo_ff) + (CNT_W+1)'(hi_ff);
   assign mid_calc  = mid_sum[CNT_W:1];
   assign count_ext = EXT_W'(count_ff);
   assign max_ext   = EXT_W'(max_ff);
   assign cap_count = (count_ext > max_ext) ? CNT_W'(max_ext) : count_ff;
   assign take      = (act_ff == ACT_TRIM) ? (rd_entry.epoch < key_ff)
                                           : (rd_entry.seq_first <= key_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      state_in        = state_ff;
      oldest_in       = oldest_ff;
      count_in        = count_ff;
      newest_epoch_in = newest_epoch_ff;
      newest_seq_in   = newest_seq_ff;
      act_in          = act_ff;
      key_in          = key_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      res_status_in   = res_status_ff;
      res_found_in    = res_found_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_word_in     = rsp_word_ff;
      mem_we          = 1'b0;
      mem_waddr       = slot_of(oldest_ff, count_ff);
      mem_wdata       = '{epoch: req_word.epoch, seq_first: req_word.sequence_req};
      mem_re          = 1'b0;
      mem_raddr       = slot_of(oldest_ff, mid_calc);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in        = req_word.action;
               res_status_in = STATUS_OK;
               res_found_in  = '0;
               state_in      = ST_EMIT;
               case (req_word.action)
                  ACT_APPEND: begin
                     if (count_ff != '0 && (newest_epoch_ff >= req_word.epoch ||
                                            newest_seq_ff >= req_word.sequence_req)) begin
                        res_status_in = STATUS_MISORDERED;
                     end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        mem_we          = 1'b1;
                        count_in        = count_ff + CNT_W'(1);
                        newest_epoch_in = req_word.epoch;
                        newest_seq_in   = req_word.sequence_req;
                     end
                  end
                  ACT_TRIM: begin
                     key_in   = req_word.epoch;
                     state_in = ST_CAP;
                  end
                  ACT_LOOKUP: begin
                     key_in = req_word.sequence_req;
                     lo_in  = '0;
                     hi_in  = count_ff;
                     // past the newest entry (or empty): no search needed
                     if (count_ff == '0 || newest_seq_ff < req_word.sequence_req) begin
                        res_status_in = STATUS_NOT_FOUND;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_CAP: begin
            oldest_in = slot_of(oldest_ff, count_ff - cap_count);
            count_in  = cap_count;
            lo_in     = '0;
            hi_in     = cap_count;
            state_in  = (cap_count == '0) ? ST_EMIT : ST_READ;
         end
         ST_READ: begin
            mem_re   = 1'b1;
            mid_in   = mid_calc;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // lo counts entries known to satisfy the predicate
            if (take) begin
               lo_in = mid_ff + CNT_W'(1);
               if (act_ff == ACT_LOOKUP) begin
                  res_found_in = rd_entry.epoch;
               end
            end else begin
               hi_in = mid_ff;
            end
            if (lo_in == hi_in) begin
               state_in = ST_EMIT;
               if (act_ff == ACT_TRIM) begin
                  oldest_in = slot_of(oldest_ff, lo_in);
                  count_in  = count_ff - lo_in;
               end else if (lo_in == '0) begin
                  res_status_in = STATUS_NOT_FOUND;
                  res_found_in  = '0;
               end
            end else begin
               state_in = ST_READ;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.status       = res_status_ff;
               rsp_word_in.found_epoch  = res_found_ff;
               rsp_word_in.entries_held = count_ext[6:0];
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         max_ff       <= 7'd64;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            max_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      newest_epoch_ff <= newest_epoch_in;
      newest_seq_ff   <= newest_seq_in;
      act_ff          <= act_in;
      key_ff          <= key_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      res_status_ff   <= res_status_in;
      res_found_ff    <= res_found_in;
      rsp_word_ff     <= rsp_word_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_search_open: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> lo_ff < hi_ff)
      else $error("search step issued on an empty interval");

   a_search_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP |-> (hi_ff <= count_ff && mid_ff < count_ff))
      else $error("search reads outside the held entries");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside the emit state");

   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff != ST_IDLE)
      else $error("accepted word did not start processing");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// testbench: drives append, trim and lookup words into ordered_epoch_range_table with
// random gaps and stalls, predicts every result and checks it field by field.
// Depends on oert_pkg and the design's top level; reads no files.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import oert_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int IDLE_LIMIT = 4000;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Mirror of the table contents plus the results still owed by the block.
   class epoch_table_shadow;
      entry_type held[$];
      rsp_word_type owed_replies[$];
      logic [6:0] cap;
      int errors;
      int replies;
      int tally[4];

      function new();
         cap = 7'd64;
         errors = 0;
         replies = 0;
         foreach (tally[i]) tally[i] = 0;
      endfunction

      function void set_cap(logic [6:0] value);
         cap = value;
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type r;
         entry_type e;
         int hit;
         r = '0;
         case (w.action)
            ACT_APPEND: begin
               if (held.size() > 0 && (held[$].epoch >= w.epoch ||
                                       held[$].seq_first >= w.sequence_req)) begin
                  r.status = STATUS_MISORDERED;
               end else if (held.size() >= TABLE_DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  e.epoch = w.epoch;
                  e.seq_first = w.sequence_req;
                  held.insert(held.size(), e);
               end
            end
            ACT_TRIM: begin
               while (held.size() > 0 && (held[0].epoch < w.epoch || held.size() > cap))
                  held.delete(0);
            end
            ACT_LOOKUP: begin
               if (held.size() == 0 || held[0].seq_first > w.sequence_req ||
                   held[$].seq_first < w.sequence_req) begin
                  r.status = STATUS_NOT_FOUND;
               end else begin
                  // entries are strictly increasing, so stop at the first one past the query
                  hit = 0;
                  for (int i = 0; i < held.size(); i++) begin
                     if (held[i].seq_first > w.sequence_req) break;
                     hit = i;
                  end
                  r.found_epoch = held[hit].epoch;
               end
            end
            default: ;
         endcase
         r.entries_held = 7'(held.size());
         tally[r.status]++;
         owed_replies.insert(owed_replies.size(), r);
      endfunction

      function void check_reply(rsp_word_type got);
         rsp_word_type want;
         if (owed_replies.size() == 0) begin
            $display("%0t: result with nothing expected: %h", $time, got);
            errors++;
            return;
         end
         want = owed_replies[0];
         owed_replies.delete(0);
         replies++;
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.found_epoch !== want.found_epoch) begin
            $display("%0t: found_epoch expected %h, got %h", $time, want.found_epoch,
                     got.found_epoch);
            errors++;
         end
         if (got.entries_held !== want.entries_held) begin
            $display("%0t: entries_held expected %0d, got %0d", $time, want.entries_held,
                     got.entries_held);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_write_en = 1'b0;
   logic [6:0] csr_write_data = '0;

   epoch_table_shadow shadow = new();
   req_word_type outbox[$];
   logic calm = 1'b0;
   int words_sent = 0;
   int idle_cycles = 0;

   // generator side: newest in-order append and the values handed out this phase
   logic [63:0] top_epoch;
   logic [63:0] top_seq;
   logic [63:0] epoch_marks[$];
   logic [63:0] seq_marks[$];

   ordered_epoch_range_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
         $display("testbench: done, errors");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] stride();
      case ($urandom_range(0, 3))
         0: return 64'd1;
         1: return 64'($urandom_range(2, 1000));
         2: return 64'($urandom);
         default: return {24'd0, 8'($urandom_range(0, 255)), 32'($urandom)};
      endcase
   endfunction

   function automatic void queue_word(logic [1:0] action, logic [63:0] epoch,
                                      logic [63:0] seq);
      req_word_type w;
      w.action = action;
      w.epoch = epoch;
      w.sequence_req = seq;
      outbox.insert(outbox.size(), w);
   endfunction

   function automatic void append_in_order();
      top_epoch = top_epoch + stride();
      top_seq = top_seq + stride();
      epoch_marks.insert(epoch_marks.size(), top_epoch);
      seq_marks.insert(seq_marks.size(), top_seq);
      queue_word(ACT_APPEND, top_epoch, top_seq);
   endfunction

   // wait until every queued word went in and every result came back
   task automatic settle();
      do @(posedge clock); while (outbox.size() != 0 || shadow.owed_replies.size() != 0);
   endtask

   // request side: the head word leaves the queue only once it is taken
   initial begin : feed
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (outbox.size() == 0) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end else begin
            gap = calm ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            req_valid <= 1'b1;
            req_word <= outbox[0];
            do @(posedge clock); while (req_stall);
            shadow.note_request(outbox[0]);
            outbox.delete(0);
            words_sent++;
         end
      end
   end

   // result side: a nonzero hold keeps stall up until a result shows, then a bit longer
   initial begin : collect
      int hold;
      while (reset) @(posedge clock);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 4);
         if (hold == 0) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b1;
            do @(posedge clock); while (!rsp_valid);
            repeat (hold - 1) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         shadow.check_reply(rsp_word);
      end
   end

   initial begin : run
      logic [6:0] cap_now;
      logic [63:0] probe;
      int fill;
      int pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed words, max_entries still at its reset value
      queue_word(ACT_LOOKUP, '0, '0);
      queue_word(ACT_TRIM, '1, '0);
      queue_word(ACT_UNUSED, '1, '1);
      queue_word(ACT_APPEND, 64'd0, 64'd0);
      queue_word(ACT_APPEND, 64'd0, 64'd1);
      queue_word(ACT_APPEND, 64'd1, 64'd0);
      queue_word(ACT_APPEND, 64'd5, 64'd100);
      queue_word(ACT_LOOKUP, '1, 64'd0);
      queue_word(ACT_LOOKUP, '0, 64'd99);
      queue_word(ACT_LOOKUP, '0, 64'd100);
      queue_word(ACT_APPEND, 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFE);
      queue_word(ACT_APPEND, '1, '1);
      queue_word(ACT_LOOKUP, '0, '1);
      queue_word(ACT_LOOKUP, '0, 64'hFFFF_FFFF_FFFF_FFFE);
      queue_word(ACT_APPEND, '1, '1);
      queue_word(ACT_TRIM, 64'd5, '1);
      queue_word(ACT_LOOKUP, '0, 64'd0);
      queue_word(ACT_TRIM, '1, '0);
      queue_word(ACT_LOOKUP, '0, '1);
      queue_word(ACT_UNUSED, '0, '0);

      for (int phase = 0; phase < 10; phase++) begin
         settle();
         case (phase)
            0: cap_now = 7'd0;
            1: cap_now = 7'd127;
            2: cap_now = 7'd64;
            3: cap_now = 7'd1;
            4: cap_now = 7'd63;
            5: cap_now = 7'd65;
            6: cap_now = 7'd2;
            7: cap_now = 7'($urandom_range(0, 127));
            8: cap_now = 7'd32;
            default: cap_now = 7'd64;
         endcase
         csr_write_en <= 1'b1;
         csr_write_data <= cap_now;
         @(posedge clock);
         csr_write_en <= 1'b0;
         shadow.set_cap(cap_now);
         calm = (phase % 4 == 1);

         // fresh start: leave headroom so in-order strides never wrap
         top_epoch = rand64();
         top_seq = rand64();
         if (&top_epoch[63:49]) top_epoch[63] = 1'b0;
         if (&top_seq[63:49]) top_seq[63] = 1'b0;
         epoch_marks.delete();
         seq_marks.delete();
         queue_word(ACT_TRIM, '1, rand64());

         fill = (phase % 2 == 1) ? $urandom_range(64, 72) : $urandom_range(0, 40);
         repeat (fill) append_in_order();

         repeat (60) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               append_in_order();
            end else if (pick < 60) begin
               if (seq_marks.size() == 0) begin
                  probe = rand64();
               end else begin
                  probe = seq_marks[$urandom_range(0, seq_marks.size() - 1)];
                  case ($urandom_range(0, 5))
                     0: ;
                     1: probe = probe - 1;
                     2: probe = probe + 1;
                     3: probe = rand64();
                     4: probe = top_seq;
                     default: probe = top_seq + 1;
                  endcase
               end
               queue_word(ACT_LOOKUP, rand64(), probe);
            end else if (pick < 72) begin
               if (epoch_marks.size() == 0 || $urandom_range(0, 9) == 0)
                  probe = ($urandom_range(0, 1) == 0) ? 64'd0 : rand64();
               else
                  probe = epoch_marks[$urandom_range(0, epoch_marks.size() - 1)] +
                          64'($urandom_range(0, 1));
               queue_word(ACT_TRIM, probe, rand64());
            end else if (pick < 87) begin
               // one field too small, the other just past the newest entry
               if ($urandom_range(0, 1) == 0) begin
                  queue_word(ACT_APPEND, top_epoch & rand64(), top_seq + 1);
                  top_seq = top_seq + 1;
               end else begin
                  queue_word(ACT_APPEND, top_epoch + 1, top_seq & rand64());
                  top_epoch = top_epoch + 1;
               end
            end else begin
               queue_word(ACT_UNUSED, rand64(), rand64());
            end
         end
      end

      settle();
      repeat (40) @(posedge clock);
      if (shadow.owed_replies.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, shadow.owed_replies.size());
         shadow.errors += shadow.owed_replies.size();
      end
      $display("run covered %0d words and %0d results over 10 max_entries settings",
               words_sent, shadow.replies);
      $display("appends refused as full %0d, as out of order %0d; lookup misses %0d",
               shadow.tally[STATUS_FULL], shadow.tally[STATUS_MISORDERED],
               shadow.tally[STATUS_NOT_FOUND]);
      if (shadow.errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
